// ===== rtl/core/madt_pkg.sv =====
// Shared types and constants for the MADT entry stream parser.
// Used by madt_parse_core, madt_out_fifo and the top level; no dependencies.
package madt_pkg;

    // Table layout
    localparam int unsigned HDR_BYTES      = 44;
    localparam int unsigned MAX_PROCESSORS = 64;
    localparam int unsigned CPU_LIMIT      = (MAX_PROCESSORS < 127) ? MAX_PROCESSORS : 127;
    localparam int unsigned FIELD_DEPTH    = 12;

    // Record types
    localparam logic [7:0] REC_LAPIC  = 8'd0;
    localparam logic [7:0] REC_IOAPIC = 8'd1;
    localparam logic [7:0] REC_X2APIC = 8'd9;

    // Minimum record lengths per layout
    localparam logic [7:0] LEN_LAPIC  = 8'd8;
    localparam logic [7:0] LEN_IOAPIC = 8'd12;
    localparam logic [7:0] LEN_X2APIC = 8'd16;

    // Result kinds
    localparam logic [1:0] KIND_CPU    = 2'd0;
    localparam logic [1:0] KIND_IOAPIC = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Output buffer
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CW    = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  cpu_slot;
        logic [31:0] cpu_id;
        logic [31:0] ioapic_address;
        logic [31:0] irq_base;
        logic [6:0]  cpu_total;
        logic        ioapic_seen;
        logic        last;
    } t_result;

    // Up to two results produced by one input byte, in order
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

// ===== rtl/core/madt_parse_core.sv =====
// Per-byte parse state and result generation for the MADT stream.
// Depends on madt_pkg; all work for a byte is done in the accepting cycle.
module madt_parse_core
    import madt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    output t_push      o_push
);

    // State registers
    logic [31:0] r_toff, n_toff;
    logic [31:0] r_tlen, n_tlen;
    logic [7:0]  r_roff, n_roff;
    logic [7:0]  r_rtype, n_rtype;
    logic [7:0]  r_rlen, n_rlen;
    logic [7:0]  r_field [FIELD_DEPTH];
    logic [7:0]  n_field [FIELD_DEPTH];
    logic [6:0]  r_cnt, n_cnt;
    logic [31:0] r_ioa, n_ioa;
    logic [31:0] r_gsi, n_gsi;
    logic        r_iof, n_iof;
    logic        r_stop, n_stop;

    // Working values
    logic [31:0] t;
    logic [7:0]  len_use;
    logic [3:0]  fidx;
    logic        finish;
    logic        rec_v;
    logic        sum_v;
    t_result     rec_res;
    t_result     sum_res;

    always_comb begin
        // restart clears state before the byte is taken
        t       = i_first_byte ? 32'd0 : r_toff;
        n_tlen  = i_first_byte ? 32'd0 : r_tlen;
        n_roff  = i_first_byte ? 8'd0  : r_roff;
        n_rtype = i_first_byte ? 8'd0  : r_rtype;
        n_rlen  = i_first_byte ? 8'd0  : r_rlen;
        n_cnt   = i_first_byte ? 7'd0  : r_cnt;
        n_ioa   = i_first_byte ? 32'd0 : r_ioa;
        n_gsi   = i_first_byte ? 32'd0 : r_gsi;
        n_iof   = i_first_byte ? 1'b0  : r_iof;
        n_stop  = i_first_byte ? 1'b0  : r_stop;
        n_field = r_field;
        len_use = n_rlen;
        fidx    = 4'd0;
        finish  = 1'b0;
        rec_v   = 1'b0;
        rec_res = '0;

        // offset counter saturates
        n_toff = (t != 32'hFFFF_FFFF) ? t + 32'd1 : t;

        // little-endian table length, bytes 4..7
        if (t inside {[32'd4:32'd7]}) begin
            n_tlen = n_tlen | ({24'd0, i_data_byte} << {t[1:0], 3'b000});
        end

        // record walk
        if (t >= 32'(HDR_BYTES) && t < n_tlen && !n_stop) begin
            if (n_roff == 8'd0) begin
                n_rtype = i_data_byte;
                n_roff  = 8'd1;
            end else if (n_roff == 8'd1 && i_data_byte == 8'd0) begin
                n_stop = 1'b1;
            end else if (n_roff == 8'd1 && i_data_byte == 8'd1) begin
                // length one: this byte becomes the record type and the next byte its length
                n_rtype = i_data_byte;
            end else begin
                if (n_roff == 8'd1) begin
                    len_use = i_data_byte;
                    n_rlen  = i_data_byte;
                end
                if (n_roff inside {[8'd2:8'd13]}) begin
                    fidx = 4'(n_roff - 8'd2);
                    n_field[fidx] = i_data_byte;
                end
                if ({1'b0, n_roff} + 9'd1 == {1'b0, len_use}) begin
                    n_roff = 8'd0;
                    finish = 1'b1;
                end else begin
                    n_roff = n_roff + 8'd1;
                end
            end
        end

        // record completion
        if (finish) begin
            if (n_rtype == REC_LAPIC && len_use >= LEN_LAPIC) begin
                if (n_field[2][0] && n_cnt < 7'(CPU_LIMIT)) begin
                    rec_v            = 1'b1;
                    rec_res.kind     = KIND_CPU;
                    rec_res.cpu_slot = n_cnt[5:0];
                    rec_res.cpu_id   = {24'd0, n_field[1]};
                    n_cnt            = n_cnt + 7'd1;
                end
            end else if (n_rtype == REC_X2APIC && len_use >= LEN_X2APIC) begin
                if (n_field[6][0] && n_cnt < 7'(CPU_LIMIT)) begin
                    rec_v            = 1'b1;
                    rec_res.kind     = KIND_CPU;
                    rec_res.cpu_slot = n_cnt[5:0];
                    rec_res.cpu_id   = {n_field[5], n_field[4], n_field[3], n_field[2]};
                    n_cnt            = n_cnt + 7'd1;
                end
            end else if (n_rtype == REC_IOAPIC && len_use >= LEN_IOAPIC) begin
                n_ioa        = {n_field[5], n_field[4], n_field[3], n_field[2]};
                n_gsi        = {n_field[9], n_field[8], n_field[7], n_field[6]};
                n_iof        = 1'b1;
                rec_v        = 1'b1;
                rec_res.kind = KIND_IOAPIC;
            end
        end
        rec_res.ioapic_address = n_ioa;
        rec_res.irq_base       = n_gsi;
        rec_res.cpu_total      = n_cnt;
        rec_res.ioapic_seen    = n_iof;

        // end-of-table summary
        sum_v = (t >= 32'd7) && (t != 32'hFFFF_FFFF) &&
                ((t + 32'd1 == n_tlen) || (t == 32'd7 && n_tlen <= 32'd8));
        sum_res                = '0;
        sum_res.kind           = KIND_END;
        sum_res.ioapic_address = n_ioa;
        sum_res.irq_base       = n_gsi;
        sum_res.cpu_total      = n_cnt;
        sum_res.ioapic_seen    = n_iof;
        sum_res.last           = 1'b1;

        // compact into ordered slots
        o_push.valid0    = i_valid && (rec_v || sum_v);
        o_push.valid1    = i_valid && rec_v && sum_v;
        o_push.res0      = rec_v ? rec_res : sum_res;
        o_push.res0.last = !(rec_v && sum_v);
        o_push.res1      = sum_res;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toff  <= '0;
            r_tlen  <= '0;
            r_roff  <= '0;
            r_rtype <= '0;
            r_rlen  <= '0;
            r_cnt   <= '0;
            r_ioa   <= '0;
            r_gsi   <= '0;
            r_iof   <= 1'b0;
            r_stop  <= 1'b0;
        end else if (i_valid) begin
            r_toff  <= n_toff;
            r_tlen  <= n_tlen;
            r_roff  <= n_roff;
            r_rtype <= n_rtype;
            r_rlen  <= n_rlen;
            r_cnt   <= n_cnt;
            r_ioa   <= n_ioa;
            r_gsi   <= n_gsi;
            r_iof   <= n_iof;
            r_stop  <= n_stop;
        end
    end

    // Record body bytes, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_field <= n_field;
        end
    end

endmodule

// ===== rtl/core/madt_out_fifo.sv =====
// Small result buffer taking up to two results per cycle, one out per cycle while i_ready is high.
// Depends on madt_pkg.
module madt_out_fifo
    import madt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_CW-1:0]   r_cnt;
    logic                 pop;
    logic [FIFO_CW-1:0]   push_n;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign o_room  = (r_cnt <= FIFO_CW'(FIFO_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign push_n  = FIFO_CW'(i_push.valid0) + FIFO_CW'(i_push.valid1);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + push_n[FIFO_AW-1:0];
            r_rp  <= r_rp + FIFO_AW'(pop);
            r_cnt <= r_cnt + push_n - FIFO_CW'(pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.valid1) begin
            r_mem[r_wp + FIFO_AW'(1)] <= i_push.res1;
        end
    end

endmodule

// ===== rtl/core/madt_entry_stream_parser_top.sv =====
// MADT entry stream parser: one table byte per transfer in, results out.
// Results are registered in the output buffer before they are offered on the master side.
// Throughput: one byte per cycle while the output buffer has room for two results;
// a byte that ends a record and the table gives two results, queued in a four-entry output buffer.
// Reset: i_rst_n synchronous, active low; clears parse state and the output buffer.
// Depends on madt_pkg, madt_parse_core and madt_out_fifo.
module madt_entry_stream_parser_top
    import madt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] first_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // kind[1:0], cpu_slot[7:2], cpu_id[39:8],
                                         // ioapic_address[71:40], irq_base[103:72],
                                         // cpu_total[110:104], ioapic_seen[111]
    output logic         m_axis_tlast    // last
);

    logic    in_xfer;
    logic    room;
    t_push   push;
    t_result res;

    assign s_axis_tready = room;
    assign in_xfer       = s_axis_tvalid && room;

    madt_parse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_xfer),
        .i_data_byte  (s_axis_tdata),
        .i_first_byte (s_axis_tuser),
        .o_push       (push)
    );

    madt_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    // Output packing
    assign m_axis_tdata = {res.ioapic_seen, res.cpu_total, res.irq_base,
                           res.ioapic_address, res.cpu_id, res.cpu_slot, res.kind};
    assign m_axis_tlast = res.last;

endmodule

// ===== dv/tb_madt_entry_stream_parser_top.sv =====
// Self-checking testbench for madt_entry_stream_parser_top: streams interrupt-controller
// tables byte by byte and checks every result against a built-in predictor.
// Depends on madt_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_madt_entry_stream_parser_top;
    import madt_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned RANDOM_ITEMS   = 1400;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned SATURATE_TABLE = 5;
    // Record byte offsets of the enable flag byte, per record layout
    localparam int unsigned FLAG_AT_LAPIC  = 4;
    localparam int unsigned FLAG_AT_X2APIC = 8;
    localparam int unsigned NO_FLAG        = 0;

    typedef enum int unsigned {SINK_OPEN, SINK_CHOPPY, SINK_STALLING} t_sink_mode;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic         s_axis_tuser  = 1'b0;    // [0] first_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;            // kind, cpu_slot, cpu_id, ioapic_address,
                                           // irq_base, cpu_total, ioapic_seen
    logic         m_axis_tlast;            // last

    // Predicts parser results per table byte and checks what comes out
    class madt_result_tracker;
        bit [31:0]   tbl_off;
        bit [31:0]   tbl_len;
        bit [7:0]    rec_off;
        bit [7:0]    rec_type;
        bit [7:0]    rec_len;
        bit [7:0]    body [FIELD_DEPTH];
        bit [6:0]    cpus;
        bit [31:0]   io_addr;
        bit [31:0]   io_gsi;
        bit          io_seen;
        bit          halted;
        t_result     step_out[$];
        t_result     results_due[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned kind_count[4];

        function new();
            clear_parse();
            mismatches = 0;
            checked    = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        function void clear_parse();
            tbl_off  = '0;
            tbl_len  = '0;
            rec_off  = '0;
            rec_type = '0;
            rec_len  = '0;
            foreach (body[i]) body[i] = '0;
            cpus     = '0;
            io_addr  = '0;
            io_gsi   = '0;
            io_seen  = 1'b0;
            halted   = 1'b0;
        endfunction

        function void emit(bit [1:0] k, bit [5:0] slot, bit [31:0] id);
            t_result r;
            r.kind           = k;
            r.cpu_slot       = slot;
            r.cpu_id         = id;
            r.ioapic_address = io_addr;
            r.irq_base       = io_gsi;
            r.cpu_total      = cpus;
            r.ioapic_seen    = io_seen;
            r.last           = 1'b0;
            step_out.push_back(r);
        endfunction

        function bit [31:0] body_le32(int unsigned at);
            return {body[at + 3], body[at + 2], body[at + 1], body[at]};
        endfunction

        // Counter saturates; ids past the limit are dropped
        function void claim_cpu(bit [31:0] id);
            bit [5:0] slot;
            if (cpus >= CPU_LIMIT) return;
            slot = cpus[5:0];
            cpus = cpus + 7'd1;
            emit(KIND_CPU, slot, id);
        endfunction

        function void close_record();
            if (rec_type == REC_LAPIC && rec_len >= LEN_LAPIC) begin
                if (body[2][0]) claim_cpu({24'd0, body[1]});
            end else if (rec_type == REC_X2APIC && rec_len >= LEN_X2APIC) begin
                if (body[6][0]) claim_cpu(body_le32(2));
            end else if (rec_type == REC_IOAPIC && rec_len >= LEN_IOAPIC) begin
                io_addr = body_le32(2);
                io_gsi  = body_le32(6);
                io_seen = 1'b1;
                emit(KIND_IOAPIC, 6'd0, 32'd0);
            end
        endfunction

        // One byte of the record area: type, length, then body
        function void record_byte(bit [7:0] b);
            if (halted) return;
            if (rec_off == 8'd0) begin
                rec_type = b;
                rec_off  = 8'd1;
                return;
            end
            if (rec_off == 8'd1) begin
                if (b == 8'd0) begin
                    halted = 1'b1;
                    return;
                end
                // length one: that byte becomes the type, next byte is the length
                if (b == 8'd1) begin
                    rec_type = b;
                    return;
                end
                rec_len = b;
            end else if (rec_off >= 8'd2 && rec_off < 8'd2 + FIELD_DEPTH) begin
                body[rec_off - 8'd2] = b;
            end
            if ({1'b0, rec_off} + 9'd1 == {1'b0, rec_len}) begin
                rec_off = 8'd0;
                close_record();
                return;
            end
            rec_off = rec_off + 8'd1;
        endfunction

        // Called for each accepted input transfer
        function void take_table_byte(bit [7:0] b, bit f);
            bit [31:0] t;
            t_result   r;
            step_out.delete();
            if (f) clear_parse();
            t = tbl_off;
            if (t != 32'hFFFF_FFFF) tbl_off = t + 32'd1;
            if (t >= 32'd4 && t <= 32'd7) tbl_len = tbl_len | ({24'd0, b} << (8 * t[1:0]));
            if (t >= HDR_BYTES && t < tbl_len) record_byte(b);
            if (t >= 32'd7 && t != 32'hFFFF_FFFF &&
                (t + 32'd1 == tbl_len || (t == 32'd7 && tbl_len <= 32'd8)))
                emit(KIND_END, 6'd0, 32'd0);
            foreach (step_out[i]) begin
                r      = step_out[i];
                r.last = (i == step_out.size() - 1);
                results_due.push_back(r);
            end
        endfunction

        function void cmp_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
                mismatches++;
            end
        endfunction

        // Called for each accepted output transfer
        function void check_result(logic [111:0] d, logic l);
            t_result want;
            if (results_due.size() == 0) begin
                $display("%0t: result with none pending, expected nothing, actual %h/%b",
                         $time, d, l);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            checked++;
            kind_count[want.kind]++;
            cmp_field("kind",           want.kind,           d[1:0]);
            cmp_field("cpu_slot",       want.cpu_slot,       d[7:2]);
            cmp_field("cpu_id",         want.cpu_id,         d[39:8]);
            cmp_field("ioapic_address", want.ioapic_address, d[71:40]);
            cmp_field("irq_base",       want.irq_base,       d[103:72]);
            cmp_field("cpu_total",      want.cpu_total,      d[110:104]);
            cmp_field("ioapic_seen",    want.ioapic_seen,    d[111]);
            cmp_field("last",           want.last,           l);
        endfunction
    endclass

    madt_result_tracker tracker = new();

    bit [7:0]    tbl_q[$];
    int unsigned tbl_live;
    int unsigned sent_items  = 0;
    int unsigned tables_sent = 0;
    int unsigned cycle_count = 0;
    bit          tx_burst    = 1'b0;

    madt_entry_stream_parser_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Result sink: open, choppy and stalling stretches
    initial begin
        t_sink_mode mode;
        forever begin
            mode = t_sink_mode'($urandom_range(0, 2));
            repeat ($urandom_range(20, 200)) begin
                @(negedge i_clk);
                case (mode)
                    SINK_OPEN: m_axis_tready <= 1'b1;
                    SINK_CHOPPY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        if ($urandom_range(0, 24) == 0) begin
                            m_axis_tready <= 1'b0;
                            repeat ($urandom_range(8, 40)) @(negedge i_clk);
                        end else begin
                            m_axis_tready <= 1'(($urandom_range(0, 1)));
                        end
                    end
                endcase
            end
        end
    end

    // Timeout
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (tx_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One input transfer; entered and left at a falling edge
    task automatic send_byte(bit [7:0] b, bit f);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_table_byte(b, f);
        @(negedge i_clk);
    endtask

    task automatic send_table();
        foreach (tbl_q[i]) begin
            send_byte(tbl_q[i], i == 0);
            if (i < tbl_live) sent_items++;
        end
        tables_sent++;
    endtask

    // Hold the sender until every pending result is out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (tracker.results_due.size() != 0);
    endtask

    function automatic void push_header(bit [31:0] len, int unsigned n, bit rnd, bit [7:0] fill);
        for (int unsigned i = 0; i < n; i++) begin
            if (i >= 4 && i <= 7) tbl_q.push_back(len[8 * (i - 4) +: 8]);
            else tbl_q.push_back(rnd ? 8'($urandom) : fill);
        end
    endfunction

    // Patch the length field; bytes past the end are not counted
    function automatic void set_length(bit [31:0] len);
        tbl_q[4] = len[7:0];
        tbl_q[5] = len[15:8];
        tbl_q[6] = len[23:16];
        tbl_q[7] = len[31:24];
        tbl_live = (len <= 32'd8) ? 8 : len;
    endfunction

    function automatic void push_record(bit [7:0] typ, bit [7:0] len, int unsigned flag_at,
                                        bit flag_on);
        bit [7:0] b;
        tbl_q.push_back(typ);
        tbl_q.push_back(len);
        for (int unsigned i = 2; i < len; i++) begin
            b = 8'($urandom);
            if (i == flag_at) b[0] = flag_on;
            tbl_q.push_back(b);
        end
    endfunction

    function automatic void push_random_record();
        int unsigned pick;
        bit          en;
        pick = $urandom_range(0, 99);
        en   = ($urandom_range(0, 4) != 0);
        if (pick < 24) begin
            push_record(REC_LAPIC, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 14))
                        : LEN_LAPIC, FLAG_AT_LAPIC, en);
        end else if (pick < 40) begin
            push_record(REC_X2APIC, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(17, 22))
                        : LEN_X2APIC, FLAG_AT_X2APIC, en);
        end else if (pick < 56) begin
            push_record(REC_IOAPIC, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(13, 18))
                        : LEN_IOAPIC, NO_FLAG, 1'b0);
        end else if (pick < 66) begin
            // shorter than its layout
            case ($urandom_range(0, 2))
                0: push_record(REC_LAPIC, 8'($urandom_range(2, LEN_LAPIC - 1)),
                               FLAG_AT_LAPIC, 1'b1);
                1: push_record(REC_IOAPIC, 8'($urandom_range(2, LEN_IOAPIC - 1)),
                               NO_FLAG, 1'b0);
                default: push_record(REC_X2APIC, 8'($urandom_range(2, LEN_X2APIC - 1)),
                                     FLAG_AT_X2APIC, 1'b1);
            endcase
        end else if (pick < 76) begin
            push_record(8'($urandom), 8'($urandom_range(2, 24)), NO_FLAG, 1'b0);
        end else if (pick < 82) begin
            // length one: the 1 turns into the type, so an io controller record follows
            tbl_q.push_back(8'($urandom));
            push_record(REC_IOAPIC, LEN_IOAPIC, NO_FLAG, 1'b0);
        end else if (pick < 84) begin
            push_record(8'($urandom), 8'd0, NO_FLAG, 1'b0);
        end else if (pick < 86) begin
            push_record(8'($urandom), 8'd255, NO_FLAG, 1'b0);
        end else begin
            push_record(8'($urandom), 8'd2, NO_FLAG, 1'b0);
        end
    endfunction

    task automatic build_random_table();
        int unsigned r;
        bit [31:0]   len;
        tbl_q.delete();
        tx_burst = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (tables_sent == SATURATE_TABLE) begin
            // more enabled processors than the counter takes
            push_header(32'd0, HDR_BYTES, 1'b1, 8'h00);
            repeat (CPU_LIMIT + 6) begin
                if ($urandom_range(0, 3) != 0)
                    push_record(REC_LAPIC, LEN_LAPIC, FLAG_AT_LAPIC, 1'b1);
                else
                    push_record(REC_X2APIC, LEN_X2APIC, FLAG_AT_X2APIC, 1'b1);
            end
            set_length(tbl_q.size());
        end else if (r < 8) begin
            // short header; with a length of 8 or less the summary comes on byte 7, then bytes past the end
            len = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 8);
            push_header(len, $urandom_range(8, 12), 1'b1, 8'h00);
            set_length(len);
        end else if (r < 16) begin
            // noise, usually cut by the next restart
            push_header(32'd0, $urandom_range(8, 90), 1'b1, 8'h00);
            len = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(8, tbl_q.size() + 10);
            set_length(len);
        end else begin
            push_header(32'd0, HDR_BYTES, 1'b1, 8'h00);
            repeat ($urandom_range(1, 10)) push_random_record();
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = tbl_q.size();
            end else if (r < 85) begin
                len = tbl_q.size() - $urandom_range(1, 12);
            end else if (r < 92) begin
                len = tbl_q.size() + $urandom_range(1, 100);
            end else begin
                len = tbl_q.size();
                repeat ($urandom_range(1, 4)) tbl_q.push_back(8'($urandom));
            end
            set_length(len);
        end
    endtask

    // Main sequence
    initial begin
        int unsigned base;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: length 8, bytes past the end, huge length cut by restart, length 0
        tx_burst = 1'b1;
        tbl_q.delete();
        push_header(32'd8, 8, 1'b0, 8'h00);
        set_length(32'd8);
        send_table();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        tbl_q.delete();
        push_header(32'hFFFF_FFFF, 10, 1'b0, 8'hFF);
        set_length(32'hFFFF_FFFF);
        send_table();
        tbl_q.delete();
        push_header(32'd0, 8, 1'b0, 8'hFF);
        set_length(32'd0);
        send_table();
        drain_results();

        // Random tables
        base = sent_items;
        while (sent_items < base + RANDOM_ITEMS) begin
            build_random_table();
            send_table();
            if ($urandom_range(0, 9) == 0) drain_results();
        end

        s_axis_tvalid <= 1'b0;
        while (tracker.results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d tables (%0d live bytes); checked %0d results: %0d processor,",
                 tables_sent, sent_items, tracker.checked, tracker.kind_count[KIND_CPU]);
        $display("%0d io controller, %0d end of table; %0d mismatches in %0d cycles.",
                 tracker.kind_count[KIND_IOAPIC], tracker.kind_count[KIND_END],
                 tracker.mismatches, cycle_count);
        if (tracker.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/madt_pkg.sv
rtl/core/madt_parse_core.sv
rtl/core/madt_out_fifo.sv
rtl/core/madt_entry_stream_parser_top.sv
dv/tb_madt_entry_stream_parser_top.sv
